// ===== sv/mtpg_pkg.sv =====
// Shared types, constants and the slot pattern table for the memory test generator/checker.
`default_nettype none

package mtpg_pkg;

  // Widths of the halfword counter and of the port fields
  localparam int INDEX_BITS = 23;
  localparam int WIDX_W     = 23;
  localparam int LEN_W      = 24;
  localparam int HW_W       = 16;
  localparam int SLOT_W     = 5;
  localparam int WALK_W     = 4;
  localparam int CODE_W     = 3;

  // Number of halfwords in one pattern block
  localparam int BLOCK_SLOTS = 32;

  // Compare width wide enough for both the counter and the halfword count
  localparam int CMP_W = (INDEX_BITS > LEN_W - 1) ? INDEX_BITS : LEN_W - 1;

  localparam logic [LEN_W-1:0] LENGTH_RESET = LEN_W'(8388608);

  localparam logic [HW_W-1:0] VAL_ONES = 16'hffff;
  localparam logic [HW_W-1:0] VAL_ZERO = 16'h0000;
  localparam logic [HW_W-1:0] VAL_AAAA = 16'haaaa;
  localparam logic [HW_W-1:0] VAL_5555 = 16'h5555;

  // Pattern classes; the same codes report a mismatch, PAT_NONE means no error
  typedef enum logic [CODE_W-1:0] {
    PAT_NONE  = 3'd0,
    PAT_ONES  = 3'd1,
    PAT_ZERO  = 3'd2,
    PAT_AAAA  = 3'd3,
    PAT_5555  = 3'd4,
    PAT_WALK  = 3'd5,
    PAT_NWALK = 3'd6
  } pat_class_t;

  // Class chosen by each slot of a block
  localparam pat_class_t SLOT_CLASS [BLOCK_SLOTS] = '{
    PAT_ONES, PAT_ZERO, PAT_WALK, PAT_NWALK, PAT_WALK, PAT_NWALK, PAT_ZERO, PAT_5555,
    PAT_ZERO, PAT_ONES, PAT_WALK, PAT_NWALK, PAT_WALK, PAT_NWALK, PAT_ONES, PAT_5555,
    PAT_AAAA, PAT_ZERO, PAT_NWALK, PAT_WALK, PAT_NWALK, PAT_WALK, PAT_ZERO, PAT_AAAA,
    PAT_5555, PAT_ONES, PAT_NWALK, PAT_WALK, PAT_NWALK, PAT_WALK, PAT_ONES, PAT_AAAA
  };

  // Pattern class and value for the current slot
  typedef struct packed {
    pat_class_t       cls;
    logic [HW_W-1:0]  value;
  } pat_t;

endpackage

`default_nettype wire

// ===== sv/mtpg_pattern.sv =====
// Slot table lookup and pattern value decode.
`default_nettype none

module mtpg_pattern import mtpg_pkg::*; (
  input  wire logic [SLOT_W-1:0] slot_in_block,
  input  wire logic [WALK_W-1:0] walk_bit,
  output pat_t                   pat
);

  pat_class_t      cls;
  logic [HW_W-1:0] one_hot;

  assign cls     = SLOT_CLASS[slot_in_block];
  assign one_hot = HW_W'(1) << walk_bit;

  always_comb begin
    pat.cls = cls;
    case (cls)
      PAT_ONES: pat.value = VAL_ONES;
      PAT_ZERO: pat.value = VAL_ZERO;
      PAT_AAAA: pat.value = VAL_AAAA;
      PAT_5555: pat.value = VAL_5555;
      PAT_WALK: pat.value = one_hot;
      default:  pat.value = ~one_hot;
    endcase
  end

endmodule

`default_nettype wire

// ===== sv/memory_test_pattern_gen_check_core.sv =====
// Top level of the memory test pattern generator and read-back checker.
//
//  channel   dir  handshake            payload
//  request   in   req_valid/req_stall  func, read_data
//  result    out  res_valid/res_stall  word_index, expected, error_code, pass_end
//  config    in   cfg_we               cfg_wdata (length_bytes)
//
// One request gives one result, registered in the cycle after its transfer; a request can be
// taken every cycle, limited only by the result register draining.
// The request is stalled only while a result is held and the far side stalls.
// Reset (rst, synchronous) clears the counters and the result valid and sets
// the pass length to 8 MiB.
// length_bytes writes take effect on the next request; counters are kept.
`default_nettype none

module memory_test_pattern_gen_check_core import mtpg_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,

  input  wire logic              cfg_we,
  input  wire logic [LEN_W-1:0]  cfg_wdata,

  input  wire logic              req_valid,
  output logic                   req_stall,
  input  wire logic              func,
  input  wire logic [HW_W-1:0]   read_data,

  output logic                   res_valid,
  input  wire logic              res_stall,
  output logic [WIDX_W-1:0]      word_index,
  output logic [HW_W-1:0]        expected,
  output logic [CODE_W-1:0]      error_code,
  output logic                   pass_end
);

  // Configuration and walk state
  logic [LEN_W-1:0]      length_bytes;
  logic [SLOT_W-1:0]     slot_in_block;
  logic [WALK_W-1:0]     walk_bit;
  logic [INDEX_BITS-1:0] word_count;

  logic [LEN_W-2:0]      total_hw;
  logic [LEN_W-2:0]      last_off;
  logic                  last;
  logic                  acc;
  pat_t                  pat;
  pat_class_t            err;

  // Result register frees up when it is empty or being taken this cycle
  assign req_stall = res_valid && res_stall;
  assign acc       = req_valid && !req_stall;

  mtpg_pattern u_pattern (
    .slot_in_block (slot_in_block),
    .walk_bit      (walk_bit),
    .pat           (pat)
  );

  // Halfwords per pass; a pass shorter than one halfword still counts as one
  assign total_hw = length_bytes[LEN_W-1:1];
  assign last_off = (total_hw == '0) ? '0 : total_hw - 1'b1;

  // End of pass on the last offset, past it after a length change, or counter full
  assign last = (CMP_W'(word_count) >= CMP_W'(last_off)) || (word_count == '1);

  // Mismatch reports the class of the expected pattern; generate never errs
  assign err = (func && (read_data != pat.value)) ? pat.cls : PAT_NONE;

  always_ff @(posedge clk) begin
    if (rst) begin
      length_bytes <= LENGTH_RESET;
    end else if (cfg_we) begin
      length_bytes <= cfg_wdata;
    end
  end

  // Counters: restart after the last halfword, walk bit steps per full block
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_in_block <= '0;
      walk_bit      <= '0;
      word_count    <= '0;
    end else if (acc) begin
      if (last) begin
        slot_in_block <= '0;
        walk_bit      <= '0;
        word_count    <= '0;
      end else begin
        word_count    <= word_count + 1'b1;
        slot_in_block <= slot_in_block + 1'b1;
        if (slot_in_block == SLOT_W'(BLOCK_SLOTS - 1)) begin
          walk_bit <= walk_bit + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (acc) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  // Result payload, loaded on each request transfer
  always_ff @(posedge clk) begin
    if (acc) begin
      word_index <= WIDX_W'(word_count);
      expected   <= pat.value;
      error_code <= err;
      pass_end   <= last;
    end
  end

  // The slot number always tracks the low bits of the halfword offset
  a_slot_aligned: assert property (@(posedge clk) disable iff (rst)
    slot_in_block == word_count[SLOT_W-1:0])
    else $error("slot counter out of step with halfword offset");

  // Last halfword of a pass restarts every counter
  a_pass_restart: assert property (@(posedge clk) disable iff (rst)
    acc && last |=> (word_count == '0) && (walk_bit == '0) && (slot_in_block == '0))
    else $error("counters not cleared after end of pass");

  // Within a pass the offset steps by one per transfer
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    acc && !last |=> word_count == $past(word_count) + 1'b1)
    else $error("halfword offset did not advance");

  // A generate request never reports an error
  a_gen_clean: assert property (@(posedge clk) disable iff (rst)
    acc && !func |=> res_valid && (error_code == PAT_NONE))
    else $error("error reported on a generate request");

  // An empty result register never holds off a request
  a_no_false_stall: assert property (@(posedge clk) disable iff (rst)
    !res_valid |-> !req_stall)
    else $error("request stalled with empty result register");

endmodule

`default_nettype wire

// ===== tb/sv/tb_memory_test_pattern_gen_check_core.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the memory test pattern generator/checker against a pattern model.

module tb_memory_test_pattern_gen_check_core import mtpg_pkg::*;;

  localparam int LIMIT_CYCLES = 200000;

  // Request operations
  localparam logic OP_GENERATE = 1'b0;
  localparam logic OP_CHECK    = 1'b1;

  // Class of each slot in a 32-halfword block, kept independently of the design
  localparam pat_class_t BLOCK_PLAN [32] = '{
    PAT_ONES, PAT_ZERO, PAT_WALK, PAT_NWALK, PAT_WALK, PAT_NWALK, PAT_ZERO, PAT_5555,
    PAT_ZERO, PAT_ONES, PAT_WALK, PAT_NWALK, PAT_WALK, PAT_NWALK, PAT_ONES, PAT_5555,
    PAT_AAAA, PAT_ZERO, PAT_NWALK, PAT_WALK, PAT_NWALK, PAT_WALK, PAT_ZERO, PAT_AAAA,
    PAT_5555, PAT_ONES, PAT_NWALK, PAT_WALK, PAT_NWALK, PAT_WALK, PAT_ONES, PAT_AAAA
  };

  typedef struct packed {
    logic              op;
    logic [HW_W-1:0]   read_word;
  } request_t;

  typedef struct packed {
    logic [WIDX_W-1:0] word_index;
    logic [HW_W-1:0]   value;
    pat_class_t        code;
    logic              last;
  } halfword_result_t;

  // Stimulus side: every input known from time zero
  logic              clk       = 1'b0;
  logic              rst       = 1'b1;
  logic              cfg_we    = 1'b0;
  logic [LEN_W-1:0]  cfg_wdata = '0;
  logic              req_valid = 1'b0;
  logic              func      = 1'b0;
  logic [HW_W-1:0]   read_data = '0;
  logic              res_stall = 1'b0;

  logic              req_stall;
  logic              res_valid;
  logic [WIDX_W-1:0] word_index;
  logic [HW_W-1:0]   expected;
  logic [CODE_W-1:0] error_code;
  logic              pass_end;

  // Pattern model state; reset is applied once, so initialisers stand in for it
  logic [LEN_W-1:0]      model_len   = 24'd8388608;
  logic [SLOT_W-1:0]     model_slot  = '0;
  logic [WALK_W-1:0]     model_walk  = '0;
  logic [INDEX_BITS-1:0] model_count = '0;

  request_t         pending_q [$];
  halfword_result_t pattern_q [$];
  request_t         next_req;
  halfword_result_t oldest;

  int queued_cnt   = 0;
  int checked_cnt  = 0;
  int accepted_cnt = 0;
  int mismatch_cnt = 0;
  int cycle_cnt    = 0;

  always #10 clk = ~clk;

  memory_test_pattern_gen_check_core uut (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .func       (func),
    .read_data  (read_data),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .word_index (word_index),
    .expected   (expected),
    .error_code (error_code),
    .pass_end   (pass_end)
  );

  // Work out the result of one accepted request and step the pattern counters.
  task automatic predict_halfword(input logic op, input logic [HW_W-1:0] rd);
    logic [INDEX_BITS-1:0] halfwords;
    logic [HW_W-1:0]       walk_one;
    logic [HW_W-1:0]       pattern;
    pat_class_t            cls;
    halfword_result_t      r;
    // odd last byte dropped; an empty pass behaves as a single halfword
    halfwords = INDEX_BITS'(model_len >> 1);
    if (halfwords == '0) halfwords = INDEX_BITS'(1);
    cls      = BLOCK_PLAN[model_slot];
    walk_one = 16'h0001 << model_walk;
    case (cls)
      PAT_ONES: pattern = 16'hffff;
      PAT_ZERO: pattern = 16'h0000;
      PAT_AAAA: pattern = 16'haaaa;
      PAT_5555: pattern = 16'h5555;
      PAT_WALK: pattern = walk_one;
      default:  pattern = ~walk_one;
    endcase
    r.word_index = WIDX_W'(model_count);
    r.value      = pattern;
    r.code       = (op == OP_CHECK && rd != pattern) ? cls : PAT_NONE;
    // a shrunk length or a full counter also ends the pass
    r.last       = (model_count >= halfwords - 1'b1) || (&model_count);
    pattern_q.push_back(r);
    if (r.last) begin
      model_slot  = '0;
      model_walk  = '0;
      model_count = '0;
    end else begin
      model_count = model_count + 1'b1;
      if (model_slot == 5'd31) model_walk = model_walk + 1'b1;
      model_slot = model_slot + 1'b1;
    end
  endtask

  // Random gaps on both sides, except for one stretch of back-to-back traffic
  function automatic bit take_break();
    if (accepted_cnt >= 300 && accepted_cnt < 460) return 1'b0;
    return $urandom_range(0, 99) < 36;
  endfunction

  task automatic compare_field(input string name, input int unsigned want,
                               input int unsigned got);
    if (want != got) begin
      $display("%0t: %s expected 0x%0h, actual 0x%0h", $time, name, want, got);
      mismatch_cnt++;
    end
  endtask

  // Request driver: holds a stalled transfer, otherwise offers the next pending item
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      if (req_valid && !req_stall) begin
        predict_halfword(func, read_data);
        accepted_cnt++;
      end
      if (!(req_valid && req_stall)) begin
        if (pending_q.size() != 0 && !take_break()) begin
          next_req  = pending_q.pop_front();
          req_valid <= 1'b1;
          func      <= next_req.op;
          read_data <= next_req.read_word;
        end else begin
          // payload is free to wander while nothing is offered
          req_valid <= 1'b0;
          func      <= 1'($urandom);
          read_data <= 16'($urandom);
        end
      end
    end
  end

  // Result monitor: random back-pressure, in-order compare against the model
  always @(posedge clk) begin
    if (rst) begin
      res_stall <= 1'b0;
    end else begin
      if (res_valid && !res_stall) begin
        if (pattern_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual index 0x%0h", $time,
                   word_index);
          mismatch_cnt++;
        end else begin
          oldest = pattern_q.pop_front();
          compare_field("word_index", oldest.word_index, word_index);
          compare_field("expected", oldest.value, expected);
          compare_field("error_code", oldest.code, error_code);
          compare_field("pass_end", oldest.last, pass_end);
          checked_cnt++;
        end
      end
      res_stall <= take_break();
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > LIMIT_CYCLES) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic queue_request(input logic op, input logic [HW_W-1:0] rd);
    pending_q.push_back(request_t'{op: op, read_word: rd});
    queued_cnt++;
  endtask

  // Mostly pattern values and near misses, so checks both match and fail
  function automatic logic [HW_W-1:0] pick_read_word();
    logic [HW_W-1:0] walk_one;
    walk_one = 16'h0001 << $urandom_range(0, 15);
    case ($urandom_range(0, 9))
      0: return 16'hffff;
      1: return 16'h0000;
      2: return 16'haaaa;
      3: return 16'h5555;
      4: return walk_one;
      5: return ~walk_one;
      6: return 16'h5555 ^ walk_one;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic random_requests(input int n);
    repeat (n)
      queue_request(($urandom_range(0, 99) < 60) ? OP_CHECK : OP_GENERATE, pick_read_word());
  endtask

  // Every queued transfer has come back, plus a little slack for the result register
  task automatic wait_drained();
    while (checked_cnt != queued_cnt) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_length(input logic [LEN_W-1:0] len);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= len;
    model_len = len;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Most of the first block at reset length: every class matched and missed, generates ignore data
    queue_request(OP_CHECK,    16'hffff);
    queue_request(OP_CHECK,    16'hffff);
    queue_request(OP_GENERATE, 16'h1234);
    queue_request(OP_CHECK,    16'hfffe);
    queue_request(OP_CHECK,    16'h0002);
    queue_request(OP_CHECK,    16'h0000);
    queue_request(OP_CHECK,    16'h0000);
    queue_request(OP_CHECK,    16'h5555);
    queue_request(OP_CHECK,    16'h0001);
    queue_request(OP_CHECK,    16'h7fff);
    queue_request(OP_CHECK,    16'h0001);
    queue_request(OP_GENERATE, 16'h0000);
    queue_request(OP_CHECK,    16'hffff);
    queue_request(OP_CHECK,    16'hfffe);
    queue_request(OP_GENERATE, 16'hffff);
    queue_request(OP_CHECK,    16'haaaa);
    queue_request(OP_CHECK,    16'haaaa);
    queue_request(OP_GENERATE, 16'h5a5a);
    queue_request(OP_CHECK,    16'h8000);
    queue_request(OP_CHECK,    16'h0000);
    queue_request(OP_CHECK,    16'hffff);
    queue_request(OP_GENERATE, 16'h0001);
    queue_request(OP_CHECK,    16'hffff);
    queue_request(OP_CHECK,    16'h5555);
    queue_request(OP_CHECK,    16'h5555);

    // shrink mid pass: counter already past the new end, so the next transfer closes it
    write_length(24'd20);
    random_requests(12);

    // degenerate lengths: zero and one behave as one halfword, three drops its odd byte
    write_length(24'd0);
    random_requests(3);
    write_length(24'd1);
    random_requests(3);
    write_length(24'd2);
    random_requests(3);
    write_length(24'd3);
    random_requests(3);

    // largest length
    write_length(24'hffffff);
    random_requests(40);

    // a pass longer than 16 blocks, so the walking bit wraps before the pass ends
    write_length(24'd1030);
    random_requests(540);

    // short passes of random length, now and then a degenerate one
    repeat (4) begin
      write_length(($urandom_range(0, 5) == 0) ? 24'($urandom_range(0, 3))
                                                : 24'($urandom_range(2, 160)));
      random_requests($urandom_range(35, 55));
    end

    wait_drained();
    if (mismatch_cnt == 0 && pattern_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/mtpg_pkg.sv
sv/mtpg_pattern.sv
sv/memory_test_pattern_gen_check_core.sv
tb/sv/tb_memory_test_pattern_gen_check_core.sv
